// File: src/dcmm_pkg.sv
// Package for the daisy-chain memory map controller.
// Holds item types, opcode and region codes and the nibble CRC step.
// No dependencies.
package dcmm_pkg;

    localparam logic [2:0] OP_UNCFG_ALL = 3'd0;
    localparam logic [2:0] OP_CONFIG    = 3'd1;
    localparam logic [2:0] OP_UNCFG     = 3'd2;
    localparam logic [2:0] OP_ID        = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;
    localparam logic [2:0] OP_WRITE     = 3'd5;

    localparam logic [2:0] REG_ROM   = 3'd0;
    localparam logic [2:0] REG_CARD1 = 3'd1;
    localparam logic [2:0] REG_CARD2 = 3'd2;
    localparam logic [2:0] REG_RAM   = 3'd3;
    localparam logic [2:0] REG_HDW   = 3'd4;

    // slot indexes of the sized regions
    localparam int SLOT_RAM   = 0;
    localparam int SLOT_CARD1 = 1;
    localparam int SLOT_CARD2 = 2;

    localparam logic [20:0] FULL_SPACE     = 21'h100000;
    localparam logic [20:0] SIZE_RAM_RST   = 21'h20000;
    localparam logic [20:0] SIZE_CARD_RST  = 21'h08000;
    localparam logic [19:0] ID_HDW         = 20'h00019;
    localparam logic [7:0]  ID_SIZE        = 8'h03;
    localparam logic [7:0]  ID_BASE        = 8'hf4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [19:0] value;
        logic [3:0]  data_nibble;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  region;
        logic [5:0]  hdw_offset;
        logic        write_accepted;
        logic [19:0] id_value;
        logic [15:0] crc_value;
    } t_result;

    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // apply the held item to the map and the CRC
    } t_dp_cmd;

    // One nibble step of the bus CRC, multiplier 0x1081. The three shifted
    // copies of the nibble do not overlap, so the product is an OR.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [3:0] nib);
        logic [3:0]  n;
        logic [15:0] prod;
        n    = crc[3:0] ^ nib;
        prod = {n, 12'd0} | {5'd0, n, 7'd0} | {12'd0, n};
        return {4'd0, crc[15:4]} ^ prod;
    endfunction

endpackage

// File: src/dcmm_ctrl.sv
// Controller of the memory map unit: accept, execute, result strobe.
// Depends on dcmm_pkg.
module dcmm_ctrl
    import dcmm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_valid,
    output t_dp_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                n_valid = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign busy       = (r_state == ST_EXEC);
    assign o_valid    = r_valid;
    assign o_cmd.load = start && (r_state == ST_IDLE);
    assign o_cmd.exec = (r_state == ST_EXEC);

endmodule

// File: src/dcmm_dpath.sv
// Datapath of the memory map unit: region chain state, decode, bus CRC.
// Depends on dcmm_pkg; driven by dcmm_ctrl commands.
module dcmm_dpath
    import dcmm_pkg::*;
#(
    parameter int BANK_SHIFT = 13,
    parameter int HDW_WINDOW = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_cmd  i_cmd,
    input  t_in_item i_item,
    output t_result  o_result
);

    localparam int          BANK_W   = 20 - BANK_SHIFT;
    localparam int          LAST_W   = BANK_W + 1;
    localparam logic [19:0] HDW_MASK = 20'(HDW_WINDOW - 1);

    t_in_item    r_item;
    t_result     r_result, n_result;
    logic [19:0] r_hdw_base, n_hdw_base;
    logic        r_hdw_valid, n_hdw_valid;
    logic [19:0] r_base [3];
    logic [19:0] n_base [3];
    logic [20:0] r_size [3];
    logic [20:0] n_size [3];
    logic [2:0]  r_region_valid, n_region_valid;
    logic        r_phase, n_phase;
    logic [15:0] r_crc, n_crc;

    logic [2:0]  hit;
    logic        hdw_hit;
    logic [2:0]  region;

    // bank decode of the sized regions, one compare pair per slot
    always_comb begin
        logic [20:0]       sm1;
        logic [BANK_W-1:0] first;
        logic [LAST_W-1:0] last;
        logic [BANK_W-1:0] bank;
        bank = BANK_W'(r_item.value >> BANK_SHIFT);
        for (int i = 0; i < 3; i++) begin
            sm1    = r_size[i] - 21'd1;
            first  = BANK_W'((r_base[i] & ~sm1[19:0]) >> BANK_SHIFT);
            last   = {1'b0, first} | LAST_W'(sm1 >> BANK_SHIFT);
            hit[i] = r_region_valid[i] && (bank >= first) && ({1'b0, bank} <= last);
        end
    end

    assign hdw_hit = r_hdw_valid
        && (r_item.value >= (r_hdw_base & ~HDW_MASK))
        && (r_item.value <= (r_hdw_base | HDW_MASK));

    always_comb begin
        if (hdw_hit) begin
            region = REG_HDW;
        end else if (hit[SLOT_RAM]) begin
            region = REG_RAM;
        end else if (hit[SLOT_CARD2]) begin
            region = REG_CARD2;
        end else if (hit[SLOT_CARD1]) begin
            region = REG_CARD1;
        end else begin
            region = REG_ROM;
        end
    end

    always_comb begin
        logic [1:0]  pend;
        logic        pend_ok;
        logic [20:0] psize;
        logic [19:0] off_full;
        n_hdw_base     = r_hdw_base;
        n_hdw_valid    = r_hdw_valid;
        n_base         = r_base;
        n_size         = r_size;
        n_region_valid = r_region_valid;
        n_phase        = r_phase;
        n_crc          = r_crc;
        n_result       = '0;

        // first unconfigured slot in chain order
        pend_ok = 1'b1;
        if (!r_region_valid[0]) begin
            pend = 2'd0;
        end else if (!r_region_valid[1]) begin
            pend = 2'd1;
        end else if (!r_region_valid[2]) begin
            pend = 2'd2;
        end else begin
            pend    = 2'd0;
            pend_ok = 1'b0;
        end
        psize    = r_size[pend];
        off_full = r_item.value & HDW_MASK;

        case (r_item.opcode)
            OP_UNCFG_ALL: begin
                n_hdw_valid    = 1'b0;
                n_region_valid = '0;
                n_phase        = 1'b0;
            end
            OP_CONFIG: begin
                if (!r_hdw_valid) begin
                    n_hdw_base  = r_item.value;
                    n_hdw_valid = 1'b1;
                end else if (pend_ok) begin
                    if (!r_phase) begin
                        n_size[pend] = FULL_SPACE - {1'b0, r_item.value};
                        n_phase      = 1'b1;
                    end else begin
                        n_base[pend]         = r_item.value;
                        n_region_valid[pend] = 1'b1;
                        n_phase              = 1'b0;
                    end
                end
            end
            OP_UNCFG: begin
                if (r_hdw_valid && r_hdw_base == r_item.value) begin
                    n_hdw_valid = 1'b0;
                    n_phase     = 1'b0;
                end else if (r_region_valid[SLOT_RAM] && r_base[SLOT_RAM] == r_item.value) begin
                    n_region_valid[SLOT_RAM] = 1'b0;
                    n_phase                  = 1'b0;
                end else if (r_region_valid[SLOT_CARD2]
                             && r_base[SLOT_CARD2] == r_item.value) begin
                    n_region_valid[SLOT_CARD2] = 1'b0;
                    n_phase                    = 1'b0;
                end else if (r_region_valid[SLOT_CARD1]
                             && r_base[SLOT_CARD1] == r_item.value) begin
                    n_region_valid[SLOT_CARD1] = 1'b0;
                    n_phase                    = 1'b0;
                end
            end
            OP_ID: begin
                if (!r_hdw_valid) begin
                    n_result.id_value = ID_HDW;
                end else if (pend_ok) begin
                    n_result.id_value = {psize[19:8], r_phase ? ID_BASE : ID_SIZE};
                end
            end
            OP_READ: begin
                n_result.region = region;
                if (region == REG_HDW) begin
                    n_result.hdw_offset = off_full[5:0];
                    n_crc = crc_step(r_crc, 4'd0);   // HDW data is masked out
                end else begin
                    n_crc = crc_step(r_crc, r_item.data_nibble);
                end
            end
            OP_WRITE: begin
                n_result.region         = region;
                n_result.write_accepted = (region != REG_ROM);
                if (region == REG_HDW) begin
                    n_result.hdw_offset = off_full[5:0];
                end
            end
            default: begin
            end
        endcase
        n_result.crc_value = n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdw_base     <= '0;
            r_hdw_valid    <= 1'b0;
            r_base[0]      <= '0;
            r_base[1]      <= '0;
            r_base[2]      <= '0;
            r_size[0]      <= SIZE_RAM_RST;
            r_size[1]      <= SIZE_CARD_RST;
            r_size[2]      <= SIZE_CARD_RST;
            r_region_valid <= '0;
            r_phase        <= 1'b0;
            r_crc          <= '0;
        end else if (i_cmd.exec) begin
            r_hdw_base     <= n_hdw_base;
            r_hdw_valid    <= n_hdw_valid;
            r_base         <= n_base;
            r_size         <= n_size;
            r_region_valid <= n_region_valid;
            r_phase        <= n_phase;
            r_crc          <= n_crc;
        end
    end

    assign o_result = r_result;

endmodule

// File: src/daisy_chain_memory_map_controller_unit.sv
// Daisy-chain memory map controller: five-region nibble address map with bus CRC.
// Channels: command input (start/busy), result output with a one-cycle strobe.
// Usage:
//   Drive i_item and raise start. The item is taken at a rising edge where
//   start is high and busy is low. busy is high for one cycle after that while
//   the datapath applies the item to the region chain and the CRC.
//   The result is registered on o_result as busy falls, with o_valid high for
//   exactly one cycle.
//   The receiver cannot stall; it must take the result in that cycle.
// Items are not overlapped: start is ignored while busy, as the two-state
//   controller (capture, then execute) handles one item at a time. A new item
//   may be issued in the cycle the previous result is strobed.
// Every opcode produces exactly one result. region, hdw_offset,
//   write_accepted and id_value are zero where the opcode does not set them;
//   crc_value always shows the running CRC.
// Reset (synchronous, i_rst_n low): all regions unconfigured, sizes back to
//   RAM 0x20000 and cards 0x8000, bases and CRC zero, no result pending.
// Depends on dcmm_pkg, dcmm_ctrl, dcmm_dpath.
module daisy_chain_memory_map_controller_unit
    import dcmm_pkg::*;
#(
    parameter int BANK_SHIFT = 13,
    parameter int HDW_WINDOW = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_in_item i_item,
    output logic     o_valid,
    output t_result  o_result
);

    t_dp_cmd cmd;

    dcmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    dcmm_dpath #(
        .BANK_SHIFT (BANK_SHIFT),
        .HDW_WINDOW (HDW_WINDOW)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule
